// File: src/slot_pool_with_occupancy_flags_top_defines.svh
// Assertion macros for the slot pool checker.
// Used by spof_checker; relies on clk and rst_n in the including scope.
`ifndef SLOT_POOL_WITH_OCCUPANCY_FLAGS_TOP_DEFINES_SVH
`define SLOT_POOL_WITH_OCCUPANCY_FLAGS_TOP_DEFINES_SVH

// same-cycle implication
`define SPOF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spof check failed");

// next-cycle implication
`define SPOF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spof check failed");

`endif

// File: src/spof_pkg.sv
// Shared types and constants for the slot pool block.
// No dependencies.
package spof_pkg;

    typedef logic [2:0] req_code_t;
    typedef logic [1:0] status_t;

    localparam req_code_t REQ_PUT    = 3'd0;
    localparam req_code_t REQ_SET    = 3'd1;
    localparam req_code_t REQ_GET    = 3'd2;
    localparam req_code_t REQ_REMOVE = 3'd3;
    localparam req_code_t REQ_CLEAR  = 3'd4;
    localparam req_code_t REQ_SWAP   = 3'd5;

    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_NO_FREE = 2'd1;
    localparam status_t STAT_EMPTY   = 2'd2;
    localparam status_t STAT_RANGE   = 2'd3;

    localparam int SLOT_W = 4;
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;

    // stream payload layout
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;
    localparam int M_PAD_W   = M_TDATA_W - (SLOT_W + DATA_W + CNT_W + 2);

    // register port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic [CNT_W-1:0] SLOTS_IN_USE_RESET = 5'd16;

endpackage

// File: src/spof_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spof_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/slot_pool_with_occupancy_flags_top.sv
// Slot pool allocator: occupancy flags, occupied count, item store in RAM.
// Depends on spof_pkg and spof_ram.
//
// Usage:
//   Requests come in on the s_* stream (req_type in s_tuser), one result per
//   request leaves on the m_* stream (status in m_tuser). slots_in_use is
//   written over the APB port at byte address 0 while the pool is idle; the
//   user must keep to that, the block itself does not enforce it.
//   The block works on one request at a time under a small sequencer that
//   reuses a single ">= capacity" comparator and a one-port-read RAM.
//   A request passes a check step and then, as needed, a read wait (get), the
//   free-slot scan (put) or two reads and two writes (swap) before its result
//   loads. The put search probes one flag per cycle, so the free-slot scan
//   sets the worst case. s_tready rises as the result loads, so a new request
//   is taken only once the last one is through.
//   Results sit in an output register; if m_tready is low the block still
//   takes the next request and finishes it, then holds in its last step
//   until the register frees up. Reset clears flags, count, the output valid
//   flag and sets slots_in_use to 16; the item RAM is not cleared.
module slot_pool_with_occupancy_flags_top #(
    parameter int SLOTS     = 16,
    parameter int ITEM_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] slot_index, [7:4] other_index, [39:8] item_data
    input  logic [spof_pkg::S_TDATA_W-1:0]      s_tdata,
    // [2:0] req_type
    input  logic [spof_pkg::S_TUSER_W-1:0]      s_tuser,
    // stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] chosen_slot, [35:4] read_data, [40:36] occupied_count,
    // [41] is_empty, [42] is_full, [47:43] zero
    output logic [spof_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [spof_pkg::M_TUSER_W-1:0]      m_tuser,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spof_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [spof_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [spof_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import spof_pkg::*;

    // only slots below 32 can ever be addressed (capacity is 5 bits)
    localparam int USED_SLOTS = (SLOTS < 32) ? SLOTS : 32;
    localparam int IDX_W      = $clog2(USED_SLOTS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHK    = 4'd1;
    localparam logic [3:0] ST_CHKB   = 4'd2;
    localparam logic [3:0] ST_SCAN   = 4'd3;
    localparam logic [3:0] ST_RDA    = 4'd4;
    localparam logic [3:0] ST_RDB    = 4'd5;
    localparam logic [3:0] ST_WRB    = 4'd6;
    localparam logic [3:0] ST_RDWAIT = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    // control state
    logic [3:0]              state_reg, state_next;
    logic [USED_SLOTS-1:0]   flags_reg, flags_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        slots_in_use_reg, slots_in_use_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // working payload
    req_code_t               req_reg, req_next;
    logic [CNT_W-1:0]        a_reg, a_next;
    logic [CNT_W-1:0]        b_reg, b_next;
    logic [DATA_W-1:0]       item_reg, item_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        steps_reg, steps_next;
    status_t                 status_reg, status_next;
    logic [SLOT_W-1:0]       chosen_reg, chosen_next;
    logic [DATA_W-1:0]       rdata_reg, rdata_next;
    logic [ITEM_BITS-1:0]    tmp_reg, tmp_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    status_t                 m_tuser_reg, m_tuser_next;

    // RAM port
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ITEM_BITS-1:0]    ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ITEM_BITS-1:0]    ram_rdata;

    logic [CNT_W-1:0]        cap_now;
    logic [CNT_W-1:0]        cmp_op;
    logic                    cmp_ge;
    logic [CNT_W-1:0]        idx_inc;
    logic [IDX_W-1:0]        a_idx;
    logic [IDX_W-1:0]        b_idx;
    logic [63:0]             item_ext;
    logic [63:0]             rd_ext;
    logic [CNT_W-1:0]        idx_ext;
    logic                    in_xfer;
    logic                    out_load;
    logic                    cfg_wr;

    spof_ram #(
        .WIDTH (ITEM_BITS),
        .DEPTH (USED_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[REG_SEL_BIT];
    assign prdata = paddr[REG_SEL_BIT] ? '0 : APB_DATA_W'(slots_in_use_reg);
    assign slots_in_use_next = cfg_wr ? pwdata[CNT_W-1:0] : slots_in_use_reg;

    // effective capacity
    assign cap_now = ({1'b0, slots_in_use_reg} > (CNT_W + 1)'(USED_SLOTS))
                   ? CNT_W'(USED_SLOTS) : slots_in_use_reg;

    assign a_idx    = a_reg[IDX_W-1:0];
    assign b_idx    = b_reg[IDX_W-1:0];
    assign idx_ext  = CNT_W'(idx_reg);
    assign idx_inc  = idx_ext + CNT_W'(1);
    assign item_ext = {32'd0, item_reg};
    assign rd_ext   = 64'(ram_rdata);

    // shared comparator: operand picked by the sequencer step
    always_comb
    begin
        case (state_reg)
            ST_CHK:  cmp_op = (req_reg == REQ_PUT) ? count_reg : a_reg;
            ST_CHKB: cmp_op = b_reg;
            ST_SCAN: cmp_op = idx_inc;
            default: cmp_op = a_reg;
        endcase
    end
    assign cmp_ge = (cmp_op >= cap_now);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next  = state_reg;
        flags_next  = flags_reg;
        count_next  = count_reg;
        req_next    = req_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        item_next   = item_reg;
        idx_next    = idx_reg;
        steps_next  = steps_reg;
        status_next = status_reg;
        chosen_next = chosen_reg;
        rdata_next  = rdata_reg;
        tmp_next    = tmp_reg;
        ram_we      = 1'b0;
        ram_waddr   = a_idx;
        ram_wdata   = item_ext[ITEM_BITS-1:0];
        ram_raddr   = a_idx;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    req_next    = s_tuser;
                    a_next      = CNT_W'(s_tdata[3:0]);
                    b_next      = CNT_W'(s_tdata[7:4]);
                    item_next   = s_tdata[39:8];
                    status_next = STAT_OK;
                    chosen_next = s_tdata[3:0];
                    rdata_next  = '0;
                    state_next  = ST_CHK;
                end
            end

            ST_CHK:
            begin
                state_next = ST_FINISH;
                case (req_reg)
                    REQ_PUT:
                    begin
                        chosen_next = '0;
                        if (cap_now == '0)
                        begin
                            status_next = STAT_NO_FREE;
                        end
                        else
                        begin
                            // start at the count, or at zero once it reaches capacity
                            idx_next   = cmp_ge ? '0 : count_reg[IDX_W-1:0];
                            steps_next = cap_now - CNT_W'(1);
                            state_next = ST_SCAN;
                        end
                    end
                    REQ_SET:
                    begin
                        if (cmp_ge)
                        begin
                            status_next = STAT_RANGE;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                            if (!flags_reg[a_idx])
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            flags_next[a_idx] = 1'b1;
                        end
                    end
                    REQ_GET:
                    begin
                        if (cmp_ge)
                        begin
                            status_next = STAT_RANGE;
                        end
                        else if (flags_reg[a_idx])
                        begin
                            state_next = ST_RDWAIT;
                        end
                        else
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (cmp_ge)
                        begin
                            status_next = STAT_RANGE;
                        end
                        else if (flags_reg[a_idx])
                        begin
                            flags_next[a_idx] = 1'b0;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    REQ_CLEAR:
                    begin
                        flags_next = '0;
                        count_next = '0;
                    end
                    REQ_SWAP:
                    begin
                        if (cmp_ge)
                        begin
                            status_next = STAT_RANGE;
                        end
                        else
                        begin
                            state_next = ST_CHKB;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_CHKB:
            begin
                if (cmp_ge)
                begin
                    status_next = STAT_RANGE;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    state_next = ST_RDA;
                end
            end

            ST_RDA:
            begin
                // item of slot a is on the read port now
                tmp_next   = ram_rdata;
                ram_raddr  = b_idx;
                state_next = ST_RDB;
            end

            ST_RDB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = a_idx;
                ram_wdata  = ram_rdata;
                state_next = ST_WRB;
            end

            ST_WRB:
            begin
                ram_we            = 1'b1;
                ram_waddr         = b_idx;
                ram_wdata         = tmp_reg;
                flags_next[a_idx] = flags_reg[b_idx];
                flags_next[b_idx] = flags_reg[a_idx];
                state_next        = ST_FINISH;
            end

            ST_RDWAIT:
            begin
                rdata_next = rd_ext[DATA_W-1:0];
                state_next = ST_FINISH;
            end

            ST_SCAN:
            begin
                if (!flags_reg[idx_reg])
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = idx_reg;
                    flags_next[idx_reg] = 1'b1;
                    count_next          = count_reg + CNT_W'(1);
                    chosen_next         = idx_ext[SLOT_W-1:0];
                    state_next          = ST_FINISH;
                end
                else if (steps_reg == '0)
                begin
                    status_next = STAT_NO_FREE;
                    chosen_next = '0;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    steps_next = steps_reg - CNT_W'(1);
                    idx_next   = cmp_ge ? '0 : idx_inc[IDX_W-1:0];
                end
            end

            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = status_reg;
            m_tdata_next  = {{M_PAD_W{1'b0}},
                             (count_reg == cap_now),
                             (count_reg == '0),
                             count_reg,
                             rdata_reg,
                             chosen_reg};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            flags_reg        <= '0;
            count_reg        <= '0;
            slots_in_use_reg <= SLOTS_IN_USE_RESET;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            flags_reg        <= flags_next;
            count_reg        <= count_next;
            slots_in_use_reg <= slots_in_use_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        item_reg    <= item_next;
        idx_reg     <= idx_next;
        steps_reg   <= steps_next;
        status_reg  <= status_next;
        chosen_reg  <= chosen_next;
        rdata_reg   <= rdata_next;
        tmp_reg     <= tmp_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

// File: src/spof_checker.sv
// Port-level checks for the slot pool, bound to the top level.
// Depends on spof_pkg and slot_pool_with_occupancy_flags_top_defines.svh.
`include "slot_pool_with_occupancy_flags_top_defines.svh"

module spof_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [spof_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [spof_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [spof_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [spof_pkg::M_TUSER_W-1:0]   m_tuser
);

    import spof_pkg::*;

    // a held result keeps its payload
    `SPOF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // an accepted request leaves the block busy in the next cycle
    `SPOF_ASSERT_NEXT(a_busy_after_xfer, s_tvalid && s_tready, !s_tready)

    // empty flag agrees with the reported count
    `SPOF_ASSERT_NOW(a_empty_flag, m_tvalid, m_tdata[41] == (m_tdata[40:36] == 5'd0))

    // read data only on a successful request
    `SPOF_ASSERT_NOW(a_rdata_zero, m_tvalid && (m_tuser != STAT_OK), m_tdata[35:4] == 32'd0)

endmodule

bind slot_pool_with_occupancy_flags_top spof_checker u_spof_checker (.*);

// File: bench/slot_pool_with_occupancy_flags_top_test.sv
// Self-checking bench for slot_pool_with_occupancy_flags_top: directed table, then random phases.
// Needs spof_pkg and the RTL. The expected transfers come from a local model of the pool.
`timescale 1ns / 1ps

module slot_pool_with_occupancy_flags_top_test;
    import spof_pkg::*;

    localparam int POOL_SLOTS      = 16;
    localparam int ITEMS_PER_PHASE = 58;
    localparam int HOLD_AFTER      = 150;     // responses taken before the long stall
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;      // outlasts the slowest put
    localparam int CYCLE_LIMIT     = 200000;

    localparam logic [APB_ADDR_W-1:0] SLOTS_IN_USE_ADDR = 3'd0;

    // request codes the block treats as no-ops
    localparam req_code_t REQ_RSVD6 = 3'd6;
    localparam req_code_t REQ_RSVD7 = 3'd7;

    typedef struct packed {
        req_code_t         req_type;
        logic [SLOT_W-1:0] slot_index;
        logic [SLOT_W-1:0] other_index;
        logic [DATA_W-1:0] item_data;
    } pool_req_t;

    // field order matters: directed rows are written as concatenations
    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] chosen_slot;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  occupied_count;
        logic              is_empty;
        logic              is_full;
    } pool_resp_t;

    typedef struct {
        pool_req_t  req;
        bit         known;
        pool_resp_t resp;
    } table_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // local copy of the pool: flags, items, count and the capacity register
    bit                pool_occupied [POOL_SLOTS];
    logic [DATA_W-1:0] pool_items    [POOL_SLOTS];
    int unsigned       pool_count = 0;
    logic [CNT_W-1:0]  pool_siu   = SLOTS_IN_USE_RESET;

    pool_resp_t  awaited_responses[$];
    table_row_t  req_table[$];
    int unsigned mismatch_count = 0;
    int unsigned responses_seen = 0;
    int unsigned cycle_count    = 0;
    bit          no_idle        = 1'b0;
    bit          long_hold_done = 1'b0;

    // slots_in_use settings walked by the random part: extremes, zero and past the pool size
    int unsigned capacity_plan[9] = '{16, 1, 7, 0, 31, 3, 16, 12, 2};

    slot_pool_with_occupancy_flags_top #(
        .SLOTS     (POOL_SLOTS),
        .ITEM_BITS (DATA_W)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // single reset at the start
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard stop if the handshakes ever hang
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Pool behavior for one request; updates the local state and returns the response.
    function automatic pool_resp_t apply_to_pool(pool_req_t r);
        pool_resp_t        resp;
        int unsigned       cap;
        int unsigned       start;
        int unsigned       s;
        int unsigned       k;
        int unsigned       a;
        int unsigned       b;
        bit                found;
        bit                tmp_flag;
        logic [DATA_W-1:0] tmp_item;

        cap = (pool_siu > POOL_SLOTS) ? POOL_SLOTS : pool_siu;
        a = r.slot_index;
        b = r.other_index;
        resp = '0;
        resp.status = STAT_OK;
        resp.chosen_slot = r.slot_index;
        case (r.req_type)
            REQ_PUT:
            begin
                // scan starts at the count, wraps to slot 0; a count at or past capacity starts at 0
                resp.chosen_slot = '0;
                found = 1'b0;
                start = (pool_count < cap) ? pool_count : 0;
                for (k = 0; k < cap && !found; k++)
                begin
                    s = start + k;
                    if (s >= cap)
                        s -= cap;
                    if (!pool_occupied[s])
                    begin
                        found = 1'b1;
                        resp.chosen_slot = s[SLOT_W-1:0];
                    end
                end
                if (found)
                begin
                    pool_items[resp.chosen_slot] = r.item_data;
                    pool_occupied[resp.chosen_slot] = 1'b1;
                    pool_count++;
                end
                else
                    resp.status = STAT_NO_FREE;
            end
            REQ_SET:
            begin
                if (a >= cap)
                    resp.status = STAT_RANGE;
                else
                begin
                    if (!pool_occupied[a])
                        pool_count++;
                    pool_items[a] = r.item_data;
                    pool_occupied[a] = 1'b1;
                end
            end
            REQ_GET:
            begin
                if (a >= cap)
                    resp.status = STAT_RANGE;
                else if (pool_occupied[a])
                    resp.read_data = pool_items[a];
                else
                    resp.status = STAT_EMPTY;
            end
            REQ_REMOVE:
            begin
                if (a >= cap)
                    resp.status = STAT_RANGE;
                else if (pool_occupied[a])
                begin
                    pool_occupied[a] = 1'b0;
                    pool_count--;
                end
            end
            REQ_CLEAR:
            begin
                // frees every flag, also those past the capacity
                foreach (pool_occupied[i])
                    pool_occupied[i] = 1'b0;
                pool_count = 0;
            end
            REQ_SWAP:
            begin
                if (a >= cap || b >= cap)
                    resp.status = STAT_RANGE;
                else
                begin
                    tmp_item = pool_items[a];
                    tmp_flag = pool_occupied[a];
                    pool_items[a] = pool_items[b];
                    pool_occupied[a] = pool_occupied[b];
                    pool_items[b] = tmp_item;
                    pool_occupied[b] = tmp_flag;
                end
            end
            default:
            begin
            end
        endcase
        resp.occupied_count = pool_count[CNT_W-1:0];
        resp.is_empty = (pool_count == 0);
        resp.is_full = (pool_count == cap);
        return resp;
    endfunction

    function automatic void add_row(req_code_t op, int a, int b, logic [DATA_W-1:0] d,
                                    bit known = 1'b0, pool_resp_t resp = '0);
        table_row_t row;

        row.req.req_type    = op;
        row.req.slot_index  = a[SLOT_W-1:0];
        row.req.other_index = b[SLOT_W-1:0];
        row.req.item_data   = d;
        row.known = known;
        row.resp  = resp;
        req_table.push_back(row);
    endfunction

    // Directed rows at the reset capacity of 16. Known rows are
    // {status, chosen_slot, read_data, occupied_count, is_empty, is_full}.
    // Every slot gets written here, so later swaps never move unwritten RAM words.
    function automatic void load_table();
        add_row(REQ_GET, 3, 0, 32'h0, 1'b1, {STAT_EMPTY, 4'd3, 32'h0, 5'd0, 1'b1, 1'b0});
        add_row(REQ_REMOVE, 15, 0, 32'h0, 1'b1, {STAT_OK, 4'd15, 32'h0, 5'd0, 1'b1, 1'b0});
        add_row(REQ_RSVD7, 9, 6, 32'hDEAD_BEEF, 1'b1, {STAT_OK, 4'd9, 32'h0, 5'd0, 1'b1, 1'b0});
        add_row(REQ_SET, 15, 0, 32'hFFFF_FFFF, 1'b1, {STAT_OK, 4'd15, 32'h0, 5'd1, 1'b0, 1'b0});
        // fills slots 1..14, then the scan wraps past occupied slot 15 to slot 0
        for (int k = 0; k < 15; k++)
            add_row(REQ_PUT, 15 - k, k, (k == 0) ? 32'h0 : (32'h8000_0001 ^ (32'h1 << k)));
        add_row(REQ_PUT, 0, 0, 32'h1234_5678, 1'b1, {STAT_NO_FREE, 4'd0, 32'h0, 5'd16, 1'b0, 1'b1});
        add_row(REQ_GET, 15, 0, 32'h0, 1'b1, {STAT_OK, 4'd15, 32'hFFFF_FFFF, 5'd16, 1'b0, 1'b1});
        add_row(REQ_SET, 5, 0, 32'hA5A5_5A5A);
        add_row(REQ_SWAP, 0, 15, 32'h0);
        add_row(REQ_GET, 0, 0, 32'h0, 1'b1, {STAT_OK, 4'd0, 32'hFFFF_FFFF, 5'd16, 1'b0, 1'b1});
        add_row(REQ_REMOVE, 15, 0, 32'h0);
        add_row(REQ_GET, 15, 0, 32'h0, 1'b1, {STAT_EMPTY, 4'd15, 32'h0, 5'd15, 1'b0, 1'b0});
        add_row(REQ_SET, 15, 0, 32'h0F0F_F0F0);
        add_row(REQ_CLEAR, 6, 0, 32'h0, 1'b1, {STAT_OK, 4'd6, 32'h0, 5'd0, 1'b1, 1'b0});
    endfunction

    // mostly in range, one pick in ten anywhere in the 4-bit field
    function automatic logic [SLOT_W-1:0] pick_slot(int unsigned cap);
        if (cap != 0 && $urandom_range(0, 9) != 0)
            return SLOT_W'($urandom_range(0, cap - 1));
        return SLOT_W'($urandom_range(0, 15));
    endfunction

    function automatic pool_req_t random_request();
        pool_req_t   r;
        int unsigned cap;
        int unsigned roll;

        cap = (pool_siu > POOL_SLOTS) ? POOL_SLOTS : pool_siu;
        roll = $urandom_range(0, 99);
        // puts and sets outweigh removes and clears so the pool reaches full
        if (roll < 30)
            r.req_type = REQ_PUT;
        else if (roll < 45)
            r.req_type = REQ_SET;
        else if (roll < 63)
            r.req_type = REQ_GET;
        else if (roll < 78)
            r.req_type = REQ_REMOVE;
        else if (roll < 90)
            r.req_type = REQ_SWAP;
        else if (roll < 94)
            r.req_type = REQ_CLEAR;
        else if (roll < 97)
            r.req_type = REQ_RSVD6;
        else
            r.req_type = REQ_RSVD7;
        r.slot_index  = pick_slot(cap);
        r.other_index = pick_slot(cap);
        case ($urandom_range(0, 7))
            0:       r.item_data = '0;
            1:       r.item_data = '1;
            default: r.item_data = $urandom;
        endcase
        return r;
    endfunction

    // One request transfer on the s_* side; the response is predicted when it is taken.
    task automatic issue_request(input pool_req_t r, input bit known, input pool_resp_t typed);
        int         gap;
        pool_resp_t predicted;

        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req_type;
        s_tdata  <= {r.item_data, r.other_index, r.slot_index};
        do @(posedge clk); while (!s_tready);
        predicted = apply_to_pool(r);
        awaited_responses.push_back(known ? typed : predicted);
    endtask

    // Setup then access phase; psel stays up so back-to-back transfers chain.
    task automatic apb_transfer(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
    endtask

    // Response side: random stalls, one long hold-off so the block backs up.
    initial
    begin : response_sink
        int         gap;
        pool_resp_t want;

        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && responses_seen == HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end
            else
                gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            responses_seen++;
            if (awaited_responses.size() == 0)
            begin
                $error("response transfer with nothing outstanding: tdata 0x%0h tuser 0x%0h",
                       m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = awaited_responses.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("chosen_slot", want.chosen_slot, m_tdata[3:0]);
                check_field("read_data", want.read_data, m_tdata[35:4]);
                check_field("occupied_count", want.occupied_count, m_tdata[40:36]);
                check_field("is_empty", want.is_empty, m_tdata[41]);
                check_field("is_full", want.is_full, m_tdata[42]);
                check_field("tdata pad", '0, m_tdata[M_TDATA_W-1 -: M_PAD_W]);
            end
        end
    end

    // Request side: reset readback, directed table, then one random phase per setting.
    initial
    begin : stimulus
        logic [APB_DATA_W-1:0] readback;

        wait (rst_n === 1'b1);
        @(posedge clk);

        apb_transfer(1'b0, SLOTS_IN_USE_ADDR, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("slots_in_use", SLOTS_IN_USE_RESET, readback);

        load_table();
        foreach (req_table[i])
            issue_request(req_table[i].req, req_table[i].known, req_table[i].resp);

        foreach (capacity_plan[p])
        begin
            // register only changes with the pool idle
            s_tvalid <= 1'b0;
            while (awaited_responses.size() != 0)
                @(posedge clk);
            apb_transfer(1'b1, SLOTS_IN_USE_ADDR, capacity_plan[p], readback);
            apb_transfer(1'b0, SLOTS_IN_USE_ADDR, '0, readback);
            psel    <= 1'b0;
            penable <= 1'b0;
            check_field("slots_in_use", capacity_plan[p], readback);
            pool_siu = capacity_plan[p][CNT_W-1:0];
            // every third phase runs back to back on both sides
            no_idle = (p % 3 == 1);
            repeat (ITEMS_PER_PHASE)
                issue_request(random_request(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        // catch any stray transfer after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
